@@ rtl/scan_jump_segment_centers_macros.svh @@
// Assertion macros for the scan jump segment centers block.
`ifndef SCAN_JUMP_SEGMENT_CENTERS_MACROS_SVH
`define SCAN_JUMP_SEGMENT_CENTERS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SJSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SJSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset.
`define SJSC_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sjsc_pkg.sv @@
// Package with constants and types for the scan jump segment centers block.
`timescale 1ns / 1ps
`default_nettype none

package sjsc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int DZ_W           = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_JUMP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WMIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WMAX  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DZONE = 2'd3;

    localparam int unsigned JUMP_RST = 400;
    localparam int unsigned WMIN_RST = 10;
    localparam int unsigned WMAX_RST = 100;
    localparam int unsigned DZ_RST   = 100;

    localparam logic [2*CFG_W-1:0] JUMP2_RST = 32'(JUMP_RST * JUMP_RST);
    localparam logic [2*CFG_W-1:0] WMIN2_RST = 32'(WMIN_RST * WMIN_RST);
    localparam logic [2*CFG_W-1:0] WMAX2_RST = 32'(WMAX_RST * WMAX_RST);
    localparam logic [DZ_W-1:0]    DZ_RST_V  = 15'(DZ_RST);

    // Squared distance; big marks a coordinate difference at or above 2**16.
    typedef struct packed {
        logic                big;
        logic [2*CFG_W:0]    sum;
    } t_dist2;

endpackage

`default_nettype wire

@@ rtl/scan_jump_segment_centers.sv @@
// Top level of the scan jump segment centers block.
//
// Usage:
//   s_axis carries scan points: tdata = {point_y, point_x} (x in low bits),
//   tlast = scan_end. m_axis carries segment centers: tdata = {center_y,
//   center_x}. Thresholds are written through i_cfg_we/i_cfg_idx/i_cfg_wdata
//   while no transaction is in flight; they take effect on the next point.
//   An accepted point is held in the input register; its center, if any,
//   moves on into the output register that drives m_axis_tvalid.
//   Throughput: one point per cycle while m_axis is not stalled; the input
//   register, squared-distance compare logic and output register overlap.
//   Reset (synchronous, active low) empties both registers, clears the
//   segment state and restores the default thresholds.
//   When the receiver stalls, the held center stays on m_axis; one more
//   point waits in the input register, then s_axis_tready drops until the
//   center is taken.
`timescale 1ns / 1ps
`default_nettype none

module scan_jump_segment_centers
    import sjsc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     s_axis_tvalid,
    output logic                                          s_axis_tready,
    // tdata: point_x, point_y
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
    input  wire logic                                     s_axis_tlast,
    output logic                                          m_axis_tvalid,
    input  wire logic                                     m_axis_tready,
    // tdata: center_x, center_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]             m_axis_tdata,
    input  wire logic                                     i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]                     i_cfg_idx,
    input  wire logic [CFG_W-1:0]                         i_cfg_wdata
);

    localparam int CB = COORD_BITS;
    localparam int TW = ((2*CB+7)/8)*8;
    localparam int MW = CB + 1;
    localparam int EW = (MW > 17) ? MW : 17;
    localparam int SW = 2*CFG_W;

    function automatic logic [EW-1:0] f_absdiff(input logic signed [CB-1:0] a,
                                                input logic signed [CB-1:0] b);
        logic signed [MW-1:0] d;
        logic        [MW-1:0] m;
        d = MW'(a) - MW'(b);
        m = d[MW-1] ? $unsigned(-d) : $unsigned(d);
        return EW'(m);
    endfunction

    function automatic t_dist2 f_dist2(input logic signed [CB-1:0] ax,
                                       input logic signed [CB-1:0] ay,
                                       input logic signed [CB-1:0] bx,
                                       input logic signed [CB-1:0] by);
        logic [EW-1:0] mx;
        logic [EW-1:0] my;
        logic [SW-1:0] sqx;
        logic [SW-1:0] sqy;
        t_dist2        r;
        mx    = f_absdiff(ax, bx);
        my    = f_absdiff(ay, by);
        sqx   = SW'(mx[15:0]) * SW'(mx[15:0]);
        sqy   = SW'(my[15:0]) * SW'(my[15:0]);
        r.big = (|mx[EW-1:16]) | (|my[EW-1:16]);
        r.sum = {1'b0, sqx} + {1'b0, sqy};
        return r;
    endfunction

    // configuration, distance thresholds kept squared, dead zone kept as written
    logic [SW-1:0]   r_jump2;
    logic [SW-1:0]   r_wmin2;
    logic [SW-1:0]   r_wmax2;
    logic [DZ_W-1:0] r_dz;
    logic [SW-1:0]   cfg_sq;

    assign cfg_sq = SW'(i_cfg_wdata) * SW'(i_cfg_wdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump2 <= JUMP2_RST;
            r_wmin2 <= WMIN2_RST;
            r_wmax2 <= WMAX2_RST;
            r_dz    <= DZ_RST_V;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_JUMP:  r_jump2 <= cfg_sq;
                CFG_WMIN:  r_wmin2 <= cfg_sq;
                CFG_WMAX:  r_wmax2 <= cfg_sq;
                CFG_DZONE: r_dz    <= i_cfg_wdata[DZ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    logic                 r_in_valid;
    logic signed [CB-1:0] r_in_x;
    logic signed [CB-1:0] r_in_y;
    logic                 r_in_last;
    logic                 fire;
    logic                 in_acc;

    assign fire          = r_in_valid & (~m_axis_tvalid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | fire;
    assign in_acc        = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_x    <= s_axis_tdata[CB-1:0];
            r_in_y    <= s_axis_tdata[2*CB-1:CB];
            r_in_last <= s_axis_tlast;
        end
    end

    // segment state
    logic                 r_seen;
    logic signed [CB-1:0] r_prev_x;
    logic signed [CB-1:0] r_prev_y;
    logic signed [CB-1:0] r_start_x;
    logic signed [CB-1:0] r_start_y;
    logic                 n_seen;
    logic signed [CB-1:0] n_prev_x;
    logic signed [CB-1:0] n_prev_y;
    logic signed [CB-1:0] n_start_x;
    logic signed [CB-1:0] n_start_y;

    logic [EW-1:0]        mag_x;
    logic [EW-1:0]        mag_y;
    logic [EW-1:0]        dz_ext;
    logic                 keep;
    t_dist2               jump_d;
    t_dist2               ext_d;
    logic                 jump_hit;
    logic                 width_ok;
    logic                 emit;
    logic signed [CB:0]   sum_x;
    logic signed [CB:0]   sum_y;

    assign mag_x    = f_absdiff(r_in_x, '0);
    assign mag_y    = f_absdiff(r_in_y, '0);
    assign dz_ext   = EW'(r_dz);
    assign keep     = ~((mag_x < dz_ext) & (mag_y < dz_ext));
    assign jump_d   = f_dist2(r_in_x, r_in_y, r_prev_x, r_prev_y);
    assign ext_d    = f_dist2(r_prev_x, r_prev_y, r_start_x, r_start_y);
    assign jump_hit = jump_d.big | (jump_d.sum > {1'b0, r_jump2});
    assign width_ok = (ext_d.big | (ext_d.sum > {1'b0, r_wmin2}))
                    & ~ext_d.big & (ext_d.sum < {1'b0, r_wmax2});
    assign emit     = keep & r_seen & jump_hit & width_ok;
    assign sum_x    = (CB+1)'(r_prev_x) + (CB+1)'(r_start_x);
    assign sum_y    = (CB+1)'(r_prev_y) + (CB+1)'(r_start_y);

    always_comb begin
        n_seen    = r_seen;
        n_prev_x  = r_prev_x;
        n_prev_y  = r_prev_y;
        n_start_x = r_start_x;
        n_start_y = r_start_y;
        if (keep) begin
            if (!r_seen || jump_hit) begin
                n_start_x = r_in_x;
                n_start_y = r_in_y;
            end
            n_seen   = 1'b1;
            n_prev_x = r_in_x;
            n_prev_y = r_in_y;
        end
        if (r_in_last) begin
            n_seen    = 1'b0;
            n_prev_x  = '0;
            n_prev_y  = '0;
            n_start_x = '0;
            n_start_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= 1'b0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_start_x <= '0;
            r_start_y <= '0;
        end else if (fire) begin
            r_seen    <= n_seen;
            r_prev_x  <= n_prev_x;
            r_prev_y  <= n_prev_y;
            r_start_x <= n_start_x;
            r_start_y <= n_start_y;
        end
    end

    // output register
    logic                 r_out_valid;
    logic signed [CB-1:0] r_cx;
    logic signed [CB-1:0] r_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_cx <= sum_x[CB:1];
            r_cy <= sum_y[CB:1];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TW'({r_cy, r_cx});

endmodule

`default_nettype wire

@@ rtl/sjsc_checker.sv @@
// Port-level assertion checker for the scan jump segment centers block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "scan_jump_segment_centers_macros.svh"

module sjsc_checker
    import sjsc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic [((2*COORD_BITS+7)/8)*8-1:0]  s_axis_tdata,
    input wire logic                               s_axis_tlast,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [((2*COORD_BITS+7)/8)*8-1:0]  m_axis_tdata,
    input wire logic                               i_cfg_we,
    input wire logic [CFG_IDX_W-1:0]               i_cfg_idx,
    input wire logic [CFG_W-1:0]                   i_cfg_wdata
);

    logic s_acc;
    logic cfg_seen;

    assign s_acc    = s_axis_tvalid & s_axis_tready;
    assign cfg_seen = i_cfg_we & (i_cfg_idx == i_cfg_idx) & (i_cfg_wdata == i_cfg_wdata)
                    & (s_axis_tlast == s_axis_tlast) & (s_axis_tdata == s_axis_tdata);

    `SJSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "center changed while stalled")
    `SJSC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !m_axis_tvalid && s_axis_tready, "block not empty after reset")
    `SJSC_ASSERT_IMPL(a_out_cause, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(s_acc, 2) && !$past(cfg_seen, 1), "center without a point two cycles before")
    `SJSC_ASSERT_IMPL(a_in_free, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")

endmodule

bind scan_jump_segment_centers sjsc_checker #(
    .COORD_BITS (COORD_BITS)
) u_sjsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_idx     (i_cfg_idx),
    .i_cfg_wdata   (i_cfg_wdata)
);

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking stream testbench for scan_jump_segment_centers with a built-in segment predictor.
module testbench;
    import sjsc_pkg::*;

    localparam int CW           = COORD_BITS_DEF;
    localparam int TDW          = ((2 * CW + 7) / 8) * 8;
    localparam int CMAX         = 2 ** (CW - 1) - 1;
    localparam int CMIN         = -(2 ** (CW - 1));
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 6;
    localparam int QUIET_LIMIT  = 1500;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 eos;
    } scan_point_t;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
    } center_t;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // tdata: point_x, point_y
    logic [TDW-1:0]       s_axis_tdata  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // tdata: center_x, center_y
    logic [TDW-1:0]       m_axis_tdata;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = CFG_JUMP;
    logic [CFG_W-1:0]     i_cfg_wdata   = '0;

    // predictor copy of thresholds and segment state
    logic [CFG_W-1:0]     jump_r  = CFG_W'(JUMP_RST);
    logic [CFG_W-1:0]     wmin_r  = CFG_W'(WMIN_RST);
    logic [CFG_W-1:0]     wmax_r  = CFG_W'(WMAX_RST);
    logic [DZ_W-1:0]      dz_r    = DZ_W'(DZ_RST);
    logic                 in_scan = 1'b0;
    logic signed [CW-1:0] prev_px = '0;
    logic signed [CW-1:0] prev_py = '0;
    logic signed [CW-1:0] seg_x0  = '0;
    logic signed [CW-1:0] seg_y0  = '0;

    scan_point_t          pending_points[$];
    center_t              centers_due[$];
    scan_point_t          next_pt;
    center_t              due;
    logic signed [CW-1:0] got_x;
    logic signed [CW-1:0] got_y;
    bit                   point_taken  = 1'b0;
    bit                   tx_idle_en   = 1'b1;
    bit                   rx_idle_en   = 1'b1;
    int unsigned          tx_wait      = 0;
    int unsigned          rx_wait      = 0;
    int                   hold_reqs    = 0;
    int                   hold_seen    = 0;
    int                   quiet_cycles = 0;
    int                   mismatches   = 0;
    int                   queued_count = 0;

    scan_jump_segment_centers dut (.*);

    always #10 i_clk = ~i_clk;

    function automatic longint unsigned gap_sq(input logic signed [CW-1:0] ax,
                                               input logic signed [CW-1:0] ay,
                                               input logic signed [CW-1:0] bx,
                                               input logic signed [CW-1:0] by);
        longint dx;
        longint dy;
        dx = ax - bx;
        dy = ay - by;
        return dx * dx + dy * dy;
    endfunction

    // Advances the segment state by one point; returns 1 when a center is due.
    function automatic bit follow_point(input logic signed [CW-1:0] px,
                                        input logic signed [CW-1:0] py,
                                        input logic eos, output center_t c);
        int                ax;
        int                ay;
        longint unsigned   ext;
        logic signed [CW:0] sx;
        logic signed [CW:0] sy;
        bit                emit;
        emit = 1'b0;
        c = '0;
        ax = px;
        ay = py;
        if (ax < 0) ax = -ax;
        if (ay < 0) ay = -ay;
        if (!(ax < int'(dz_r) && ay < int'(dz_r))) begin
            if (!in_scan) begin
                seg_x0 = px;
                seg_y0 = py;
                in_scan = 1'b1;
            end else if (gap_sq(px, py, prev_px, prev_py) > jump_r * jump_r) begin
                ext = gap_sq(prev_px, prev_py, seg_x0, seg_y0);
                if (wmin_r * wmin_r < ext && ext < wmax_r * wmax_r) begin
                    sx = {prev_px[CW-1], prev_px} + {seg_x0[CW-1], seg_x0};
                    sy = {prev_py[CW-1], prev_py} + {seg_y0[CW-1], seg_y0};
                    c.cx = sx[CW:1];
                    c.cy = sy[CW:1];
                    emit = 1'b1;
                end
                seg_x0 = px;
                seg_y0 = py;
            end
            prev_px = px;
            prev_py = py;
        end
        if (eos) begin
            in_scan = 1'b0;
            prev_px = '0;
            prev_py = '0;
            seg_x0 = '0;
            seg_y0 = '0;
        end
        return emit;
    endfunction

    function automatic int unsigned idle_len(input bit enabled);
        int unsigned r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int clamp_coord(input int v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(0, 7))
            0: return CMIN;
            1: return CMAX;
            default: return int'($urandom_range(0, 2 ** CW - 1)) + CMIN;
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    task automatic queue_point(input int x, input int y, input bit eos);
        scan_point_t p;
        p.x = CW'(clamp_coord(x));
        p.y = CW'(clamp_coord(y));
        p.eos = eos;
        pending_points.push_back(p);
        queued_count++;
    endtask

    // stray point anywhere, point inside the dead zone, or a premature scan end
    task automatic queue_noise();
        int d;
        d = (dz_r == 0) ? 0 : int'(dz_r) - 1;
        case ($urandom_range(0, 3))
            0, 3: queue_point(pick_coord(), pick_coord(), 1'b0);
            1: queue_point(int'($urandom_range(0, 2 * d)) - d,
                           int'($urandom_range(0, 2 * d)) - d, 1'b0);
            default: queue_point(pick_coord(), pick_coord(), 1'b1);
        endcase
    endtask

    // One scan: segments walk along x, y or a diagonal with steps not above the jump.
    task automatic queue_scan(input int n_seg);
        int x;
        int y;
        int lim;
        int mode;
        int dirx;
        int diry;
        int npts;
        for (int s = 0; s < n_seg; s++) begin
            x = pick_coord();
            y = pick_coord();
            npts = $urandom_range(1, 5);
            mode = $urandom_range(0, 2);
            dirx = $urandom_range(0, 1) ? 1 : -1;
            diry = $urandom_range(0, 1) ? 1 : -1;
            lim = int'(jump_r);
            if (mode == 2) lim = lim * 7 / 10;
            if (lim > int'(wmax_r) / 2 + 4) lim = int'(wmax_r) / 2 + 4;
            for (int p = 0; p < npts; p++) begin
                if ($urandom_range(0, 9) == 0) queue_noise();
                queue_point(x, y, s == n_seg - 1 && p == npts - 1);
                if (mode != 1) x = clamp_coord(x + dirx * int'($urandom_range(0, lim)));
                if (mode != 0) y = clamp_coord(y + diry * int'($urandom_range(0, lim)));
            end
        end
    endtask

    task automatic queue_random(input int n);
        int start;
        start = queued_count;
        while (queued_count - start < n) queue_scan($urandom_range(1, 6));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [CFG_W-1:0] jump, input logic [CFG_W-1:0] wmin,
                                  input logic [CFG_W-1:0] wmax, input logic [CFG_W-1:0] dz);
        write_reg(CFG_JUMP, jump);
        write_reg(CFG_WMIN, wmin);
        write_reg(CFG_WMAX, wmax);
        write_reg(CFG_DZONE, dz);
    endtask

    task automatic settle();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_points.size() != 0 || s_axis_tvalid || centers_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || point_taken)) begin
            if (tx_wait != 0) begin
                tx_wait--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_points.size() != 0) begin
                next_pt = pending_points.pop_front();
                s_axis_tdata <= TDW'({next_pt.y, next_pt.x});
                s_axis_tlast <= next_pt.eos;
                s_axis_tvalid <= 1'b1;
                tx_wait = idle_len(tx_idle_en);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            rx_wait = HOLD_CYCLES;
        end
        if (rx_wait != 0) begin
            rx_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rx_wait = idle_len(rx_idle_en);
        end
    end

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        point_taken = 1'b0;
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_cfg_we) begin
                quiet_cycles = 0;
                case (i_cfg_idx)
                    CFG_JUMP:  jump_r = i_cfg_wdata;
                    CFG_WMIN:  wmin_r = i_cfg_wdata;
                    CFG_WMAX:  wmax_r = i_cfg_wdata;
                    CFG_DZONE: dz_r = i_cfg_wdata[DZ_W-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                quiet_cycles = 0;
                got_x = m_axis_tdata[CW-1:0];
                got_y = m_axis_tdata[2*CW-1:CW];
                if (centers_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected center (%0d, %0d)", got_x, got_y));
                end else begin
                    due = centers_due.pop_front();
                    if (got_x !== due.cx)
                        flag_mismatch($sformatf("center_x got %0d want %0d", got_x, due.cx));
                    if (got_y !== due.cy)
                        flag_mismatch($sformatf("center_y got %0d want %0d", got_y, due.cy));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                quiet_cycles = 0;
                point_taken = 1'b1;
                if (follow_point(s_axis_tdata[CW-1:0], s_axis_tdata[2*CW-1:CW],
                                 s_axis_tlast, due))
                    centers_due.push_back(due);
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds: dead zone, exact jump, width bounds, extremes, scan end
        queue_point(0, 0, 1'b0);
        queue_point(99, -99, 1'b0);
        queue_point(100, 0, 1'b0);
        queue_point(150, 0, 1'b0);
        queue_point(550, 0, 1'b0);
        queue_point(1000, 0, 1'b0);
        queue_point(1060, 0, 1'b0);
        queue_point(2000, 0, 1'b0);
        queue_point(2005, 0, 1'b0);
        queue_point(3000, 0, 1'b0);
        queue_point(3010, 0, 1'b0);
        queue_point(5000, 0, 1'b0);
        queue_point(5000, 100, 1'b0);
        queue_point(8000, 0, 1'b0);
        queue_point(CMIN, CMIN, 1'b0);
        queue_point(CMIN, -32700, 1'b0);
        queue_point(CMAX, CMAX, 1'b0);
        queue_point(CMAX, 32717, 1'b0);
        queue_point(-1001, -1000, 1'b1);
        queue_point(-1001, -1000, 1'b0);
        queue_point(-1060, -1000, 1'b0);
        queue_point(-3000, -3000, 1'b0);
        queue_point(-3000, -3040, 1'b0);
        queue_point(5, 5, 1'b1);
        queue_point(-3000, -3040, 1'b0);
        queue_point(5, -500, 1'b1);
        settle();

        // back-to-back traffic with a long receiver stall
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        queue_random(250);
        repeat (20) @(posedge i_clk);
        hold_reqs++;
        settle();

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        set_thresholds(16'd1, 16'd0, 16'hFFFF, 16'd0);
        queue_point(0, 0, 1'b0);
        queue_point(1, 0, 1'b0);
        queue_point(2, 0, 1'b0);
        queue_point(5, 0, 1'b1);
        queue_random(150);
        settle();

        // dead zone write carries an extra high bit
        set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_random(100);
        settle();

        set_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
        queue_random(100);
        settle();

        set_thresholds(16'd2000, 16'd100, 16'd1500, 16'd50);
        queue_random(300);
        settle();

        set_thresholds(16'd300, 16'd5, 16'd200, 16'd1000);
        queue_random(300);
        repeat (30) @(posedge i_clk);
        hold_reqs++;
        settle();

        tx_idle_en = 1'b0;
        set_thresholds(16'hFFFF, 16'd0, 16'hFFFF, 16'd10);
        queue_random(150);
        settle();

        tx_idle_en = 1'b1;
        set_thresholds(16'(JUMP_RST), 16'(WMIN_RST), 16'(WMAX_RST), 16'(DZ_RST));
        queue_random(300);
        settle();

        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
